// ===== rtl/tea_pkg.sv =====
// types, constants and the round mix function for the tea block cipher core
// no dependencies
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 2'd3;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } in_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } out_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] x0;
    logic [31:0] x1;
  } stage_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] half, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = {half[27:0], 4'b0000} + ka;
    b = half + sum;
    c = {5'b00000, half[31:5]} + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// ===== rtl/tea_round_stage.sv =====
// one half-round pipeline stage: updates one half of the block and registers it
// depends on tea_pkg
module tea_round_stage #(
  parameter logic [31:0] SUM_ENC = 32'h0,
  parameter logic [31:0] SUM_DEC = 32'h0,
  parameter bit          ODD     = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  tea_pkg::stage_t dat_in,
  input  tea_pkg::key_t   key,
  output logic            vld_out,
  output tea_pkg::stage_t dat_out
);
  import tea_pkg::*;

  logic        enc;
  logic        upd_first;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] sum;
  logic [31:0] mix;
  logic [31:0] upd;
  logic        vld_r;
  stage_t      dat_r;
  stage_t      dat_nxt;

  always_comb begin
    enc       = (dat_in.kind == KIND_ENCRYPT);
    upd_first = (enc != ODD);
    src       = upd_first ? dat_in.x1 : dat_in.x0;
    dst       = upd_first ? dat_in.x0 : dat_in.x1;
    ka        = upd_first ? key.k0 : key.k2;
    kb        = upd_first ? key.k1 : key.k3;
    sum       = enc ? SUM_ENC : SUM_DEC;
    mix       = tea_mix(src, sum, ka, kb);
    upd       = enc ? (dst + mix) : (dst - mix);
    dat_nxt   = dat_in;
    if (upd_first) begin
      dat_nxt.x0 = upd;
    end else begin
      dat_nxt.x1 = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_out = vld_r;
  assign dat_out = dat_r;

endmodule

// ===== rtl/tea_block_cipher_core.sv =====
// tea block cipher core: 2*ROUNDS half-round stages and an output register
// a block passes through every half-round stage register, then the output register, before its result is valid
// throughput one block per cycle while the result is not stalled, set by the one-half-round-per-stage pipeline
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// synchronous active-low reset clears valid bits and sets all key words to zero
// depends on tea_pkg and tea_round_stage
module tea_block_cipher_core #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tea_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tea_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_wdata
);
  import tea_pkg::*;

  localparam int unsigned STAGES = 2 * ROUNDS;

  key_t        key_r;
  logic        en;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        vld [STAGES+1];
  stage_t      dat [STAGES+1];
  logic [STAGES-1:0] vld_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_WORD0: key_r.k0 <= cfg_wdata;
        CFG_KEY_WORD1: key_r.k1 <= cfg_wdata;
        CFG_KEY_WORD2: key_r.k2 <= cfg_wdata;
        CFG_KEY_WORD3: key_r.k3 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign vld[0]        = in_valid;
  assign dat[0].kind   = in_data.kind;
  assign dat[0].x0     = in_data.first_word;
  assign dat[0].x1     = in_data.second_word;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam logic [31:0] SUM_ENC = 32'(64'(j / 2 + 1) * 64'(TEA_DELTA));
    localparam logic [31:0] SUM_DEC = 32'(64'(ROUNDS - j / 2) * 64'(TEA_DELTA));
    tea_round_stage #(
      .SUM_ENC (SUM_ENC),
      .SUM_DEC (SUM_DEC),
      .ODD     (1'(j % 2))
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (vld[j]),
      .dat_in  (dat[j]),
      .key     (key_r),
      .vld_out (vld[j+1]),
      .dat_out (dat[j+1])
    );
    assign vld_vec[j] = vld[j+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.result_first  <= dat[STAGES].x0;
      out_data_r.result_second <= dat[STAGES].x1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld[1])
    else $error("accepted block missing from first stage");

  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_vec))
    else $error("pipeline valid bits moved while frozen");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld[STAGES]) |=> out_valid_r)
    else $error("last stage block did not reach output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a held result");

endmodule

// ===== verif/tb_tea_block_cipher_core.sv =====
// self-checking testbench for tea_block_cipher_core: encrypt and decrypt transfers
// under several key settings, each result checked against a cycle-free tea predictor
// depends on tea_pkg and the tea_block_cipher_core rtl
module tb_tea_block_cipher_core;
  import tea_pkg::*;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] KEY_INDEX [4] = '{CFG_KEY_WORD0, CFG_KEY_WORD1,
                                                     CFG_KEY_WORD2, CFG_KEY_WORD3};

  class tea_cipher_board;
    logic [31:0] key_words [4];
    out_t        expected_blocks [$];
    int unsigned mismatches;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      mismatches = 0;
    endfunction

    function void set_key_word(int unsigned idx, logic [31:0] value);
      key_words[idx] = value;
    endfunction

    function logic [31:0] round_mix(logic [31:0] half, logic [31:0] sum,
                                    logic [31:0] ka, logic [31:0] kb);
      return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
    endfunction

    function out_t cipher(in_t blk);
      logic [31:0] y0;
      logic [31:0] y1;
      logic [31:0] sum;
      out_t        res;
      y0 = blk.first_word;
      y1 = blk.second_word;
      if (blk.kind == KIND_ENCRYPT) begin
        sum = '0;
        for (int r = 0; r < ROUNDS; r++) begin
          sum = sum + TEA_DELTA;
          y0 = y0 + round_mix(y1, sum, key_words[0], key_words[1]);
          y1 = y1 + round_mix(y0, sum, key_words[2], key_words[3]);
        end
      end else begin
        sum = TEA_DELTA * ROUNDS;
        for (int r = 0; r < ROUNDS; r++) begin
          y1 = y1 - round_mix(y0, sum, key_words[2], key_words[3]);
          y0 = y0 - round_mix(y1, sum, key_words[0], key_words[1]);
          sum = sum - TEA_DELTA;
        end
      end
      res.result_first = y0;
      res.result_second = y1;
      return res;
    endfunction

    function void note_block(in_t blk);
      expected_blocks.push_back(cipher(blk));
    endfunction

    function void check_block(out_t got);
      out_t want;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("error: unexpected result first=%h second=%h",
                   got.result_first, got.result_second);
      end else begin
        want = expected_blocks.pop_front();
        if (got.result_first !== want.result_first ||
            got.result_second !== want.result_second) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("error: result mismatch first exp=%h got=%h second exp=%h got=%h",
                     want.result_first, got.result_first,
                     want.result_second, got.result_second);
        end
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    function bit clean();
      return mismatches == 0 && expected_blocks.size() == 0;
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  tea_cipher_board board;
  bit              idle_on = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;

  tea_block_cipher_core #(
    .ROUNDS(ROUNDS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_block(out_data);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_t make_block(logic kind, logic [31:0] w0, logic [31:0] w1);
    in_t blk;
    blk.kind = kind;
    blk.first_word = w0;
    blk.second_word = w1;
    return blk;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input in_t blk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_block(blk);
  endtask

  // a block, then the opposite operation on its own result
  task automatic send_round_trip(input in_t blk);
    out_t mid;
    mid = board.cipher(blk);
    send_block(blk);
    send_block(make_block(~blk.kind, mid.result_first, mid.result_second));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_key(input logic [31:0] words [4], input logic [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= KEY_INDEX[i];
        cfg_wdata <= words[i];
        board.set_key_word(i, words[i]);
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] key [4];
    int unsigned count;
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_KEY_WORD0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // key left at reset value
    send_block(make_block(KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
    send_block(make_block(KIND_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff));
    send_block(make_block(KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000));
    send_block(make_block(KIND_DECRYPT, 32'hffff_ffff, 32'hffff_ffff));
    send_block(make_block(KIND_ENCRYPT, 32'h8000_0000, 32'h0000_0001));
    send_block(make_block(KIND_DECRYPT, 32'h0000_0001, 32'h8000_0000));
    wait_idle();

    key = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    write_key(key, 4'hf);
    send_block(make_block(KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
    send_block(make_block(KIND_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff));
    send_block(make_block(KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000));
    send_block(make_block(KIND_DECRYPT, 32'hffff_ffff, 32'hffff_ffff));
    send_block(make_block(KIND_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555));
    send_block(make_block(KIND_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa));
    wait_idle();

    key = '{32'h0000_0000, 32'hffff_ffff, 32'h0123_4567, 32'h89ab_cdef};
    write_key(key, 4'hf);
    send_round_trip(make_block(KIND_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef));
    send_round_trip(make_block(KIND_DECRYPT, 32'hdead_beef, 32'h0bad_f00d));
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase != RANDOM_PHASES - 1);
      foreach (key[i]) key[i] = pick_word();
      write_key(key, (phase == 0) ? 4'hf : 4'($urandom_range(1, 15)));
      count = 0;
      while (count < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 4) begin
          send_round_trip(make_block(1'($urandom), pick_word(), pick_word()));
          count += 2;
        end else begin
          send_block(make_block(1'($urandom), pick_word(), pick_word()));
          count++;
        end
      end
      wait_idle();
    end

    repeat (2 * ROUNDS + 10) @(posedge clk);
    if (board.clean()) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
